>>> rtl/core/mhpq_pkg.sv
`default_nettype none
package mhpq_pkg;
  localparam int HEAP_DEPTH    = 64;
  localparam int PRIORITY_BITS = 8;
  localparam int ADDR_BITS     = $clog2(HEAP_DEPTH);
  localparam int COUNT_BITS    = $clog2(HEAP_DEPTH + 1);
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [1:0] ST_INSERTED    = 2'd0;
  localparam logic [1:0] ST_EXTRACTED   = 2'd1;
  localparam logic [1:0] ST_REFUSE_FULL = 2'd2;
  localparam logic [1:0] ST_REFUSE_EMPTY = 2'd3;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] priority_req;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_priority;
    logic [31:0] out_id;
    logic [31:0] out_payload;
    logic [7:0]  top_priority;
    logic [6:0]  occupancy;
  } out_item_t;

  // One heap entry as stored in memory.
  typedef struct packed {
    logic [PRIORITY_BITS-1:0] prio;
    logic [31:0]              id;
    logic [31:0]              payload;
  } entry_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic [1:0]               status;
    logic [PRIORITY_BITS-1:0] prio;
    logic [31:0]              id;
    logic [31:0]              payload;
  } cmd_t;

  function automatic logic ranks_above(entry_t a, entry_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    return a.id < b.id;
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/mhpq_front.sv
`default_nettype none
module mhpq_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire mhpq_pkg::in_item_t in_item,
  output logic                   cmd_valid,
  output mhpq_pkg::cmd_t         cmd,
  input  wire logic              cmd_take
);
  // Front keeps its own fill count and id counter so it can classify items.
  logic [mhpq_pkg::COUNT_BITS-1:0] fill;
  logic [31:0] id_counter;
  mhpq_pkg::cmd_t q [mhpq_pkg::QUEUE_DEPTH];
  logic [1:0] qcount;
  logic wp, rp;
  logic acc;
  mhpq_pkg::cmd_t c;

  assign full = (qcount == 2'(mhpq_pkg::QUEUE_DEPTH));
  assign acc = push && !full;
  assign cmd_valid = (qcount != 2'd0);
  assign cmd = q[rp];

  // Classify the incoming item.
  always_comb begin
    c = '0;
    if (in_item.func == mhpq_pkg::FUNC_INSERT) begin
      if (fill == mhpq_pkg::COUNT_BITS'(mhpq_pkg::HEAP_DEPTH)) begin
        c.status = mhpq_pkg::ST_REFUSE_FULL;
      end else begin
        c.status  = mhpq_pkg::ST_INSERTED;
        c.prio    = in_item.priority_req[mhpq_pkg::PRIORITY_BITS-1:0];
        c.id      = id_counter;
        c.payload = in_item.payload;
      end
    end else begin
      c.status = (fill == '0) ? mhpq_pkg::ST_REFUSE_EMPTY : mhpq_pkg::ST_EXTRACTED;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) q[wp] <= c;
    if (rst) begin
      fill <= '0;
      id_counter <= '0;
      qcount <= '0;
      wp <= 1'b0;
      rp <= 1'b0;
    end else begin
      if (acc) begin
        wp <= ~wp;
        if (c.status == mhpq_pkg::ST_INSERTED) begin
          fill <= fill + 1'b1;
          id_counter <= id_counter + 32'd1;
        end else if (c.status == mhpq_pkg::ST_EXTRACTED) begin
          fill <= fill - 1'b1;
        end
      end
      if (cmd_take) rp <= ~rp;
      qcount <= qcount + {1'b0, acc} - {1'b0, cmd_take};
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/mhpq_back.sv
`default_nettype none
module mhpq_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  input  wire mhpq_pkg::cmd_t     cmd,
  output logic                    cmd_take,
  output logic                    empty,
  input  wire logic               pop,
  output mhpq_pkg::out_item_t     out_item
);
  localparam int AB = mhpq_pkg::ADDR_BITS;
  localparam int CB = mhpq_pkg::COUNT_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_UPRD  = 7'b0000010,
    S_UPCMP = 7'b0000100,
    S_DNRD  = 7'b0001000,
    S_DNRD2 = 7'b0010000,
    S_DNCMP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  mhpq_pkg::entry_t mem [mhpq_pkg::HEAP_DEPTH];
  mhpq_pkg::entry_t rd;
  logic [AB-1:0] raddr;
  logic [AB-1:0] waddr;
  mhpq_pkg::entry_t wdata;
  logic we;

  logic [CB-1:0] fill;
  logic [AB-1:0] pos;
  mhpq_pkg::entry_t cur, lch, root;
  logic root_valid;
  logic [CB:0] lidx, ridx;
  mhpq_pkg::cmd_t hold;
  mhpq_pkg::entry_t extracted;
  logic obuf_valid;
  mhpq_pkg::out_item_t obuf;

  // Heap memory with registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  assign lidx = {pos, 1'b1} + (CB + 1)'(0);
  assign ridx = {pos, 1'b0} + (CB + 1)'(2);
  assign empty = !obuf_valid;
  assign out_item = obuf;
  assign cmd_take = (state == S_IDLE) && cmd_valid && !obuf_valid;

  // Sequencer: one sift at a time; per level, one read up and two down.
  always_comb begin
    we = 1'b0;
    waddr = pos;
    wdata = cur;
    raddr = pos;
    case (state)
      S_IDLE: begin
        raddr = AB'(fill - 1'b1);
        if (cmd_take && cmd.status == mhpq_pkg::ST_INSERTED) begin
          we = 1'b1;
          waddr = AB'(fill);
          wdata = '{prio: cmd.prio, id: cmd.id, payload: cmd.payload};
          raddr = AB'((fill - 1'b1) >> 1);
        end
      end
      S_UPRD: raddr = AB'((pos - 1'b1) >> 1);
      S_UPCMP: begin
        if (pos != '0 && mhpq_pkg::ranks_above(cur, rd)) begin
          we = 1'b1;
          waddr = pos;
          wdata = rd;
        end else begin
          we = 1'b1;
        end
      end
      S_DNRD: raddr = AB'(lidx);
      S_DNRD2: raddr = AB'(ridx);
      S_DNCMP: begin
        we = 1'b1;
        if (lidx < (CB + 1)'(fill) && (ridx >= (CB + 1)'(fill) ||
            mhpq_pkg::ranks_above(lch, rd))) begin
          if (mhpq_pkg::ranks_above(lch, cur)) wdata = lch;
        end else if (ridx < (CB + 1)'(fill)) begin
          if (mhpq_pkg::ranks_above(rd, cur)) wdata = rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      obuf_valid <= 1'b0;
      root_valid <= 1'b0;
    end else begin
      if (pop && obuf_valid) obuf_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_take) begin
            hold <= cmd;
            extracted <= '0;
            case (cmd.status)
              mhpq_pkg::ST_INSERTED: begin
                cur <= '{prio: cmd.prio, id: cmd.id, payload: cmd.payload};
                pos <= AB'(fill);
                fill <= fill + 1'b1;
                if (fill == '0) begin
                  root <= '{prio: cmd.prio, id: cmd.id, payload: cmd.payload};
                  root_valid <= 1'b1;
                  state <= S_DONE;
                end else begin
                  state <= S_UPCMP;
                end
              end
              mhpq_pkg::ST_EXTRACTED: begin
                extracted <= root;
                fill <= fill - 1'b1;
                pos <= '0;
                if (fill == CB'(1)) begin
                  root_valid <= 1'b0;
                  state <= S_DONE;
                end else begin
                  state <= S_DNRD;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_UPRD: state <= S_UPCMP;
        S_UPCMP: begin
          if (pos != '0 && mhpq_pkg::ranks_above(cur, rd)) begin
            if (((pos - 1'b1) >> 1) == '0) root <= cur;
            pos <= AB'((pos - 1'b1) >> 1);
            state <= (((pos - 1'b1) >> 1) == '0) ? S_UPCMP : S_UPRD;
          end else begin
            if (pos == '0) root <= cur;
            state <= S_DONE;
          end
        end
        S_DNRD: begin
          // rd now holds the former last entry; it becomes the sifted item.
          if (pos == '0 && hold.status == mhpq_pkg::ST_EXTRACTED &&
              extracted == root) begin
            cur <= rd;
            root <= rd;
            hold.status <= mhpq_pkg::ST_EXTRACTED;
            state <= S_DNRD;
          end else begin
            state <= S_DNRD2;
          end
        end
        S_DNRD2: begin
          lch <= rd;
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (lidx < (CB + 1)'(fill) && (ridx >= (CB + 1)'(fill) ||
              mhpq_pkg::ranks_above(lch, rd)) && mhpq_pkg::ranks_above(lch, cur)) begin
            if (pos == '0) root <= lch;
            pos <= AB'(lidx);
            state <= S_DNRD;
          end else if (!(lidx < (CB + 1)'(fill) && (ridx >= (CB + 1)'(fill) ||
              mhpq_pkg::ranks_above(lch, rd))) && ridx < (CB + 1)'(fill) &&
              mhpq_pkg::ranks_above(rd, cur)) begin
            if (pos == '0) root <= rd;
            pos <= AB'(ridx);
            state <= S_DNRD;
          end else begin
            if (pos == '0) root <= cur;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          obuf_valid <= 1'b1;
          obuf.status <= hold.status;
          obuf.out_priority <= 8'(extracted.prio);
          obuf.out_id <= (hold.status == mhpq_pkg::ST_INSERTED) ? hold.id :
                         extracted.id;
          obuf.out_payload <= extracted.payload;
          obuf.top_priority <= root_valid ? 8'(root.prio) : 8'd0;
          obuf.occupancy <= 7'(fill);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/max_heap_priority_queue_unit.sv
`default_nettype none
// Binary max-heap priority queue with FIFO tie-break, 64 tasks.
// Input channel: push/full with func, priority_req and payload. An item is
// taken when push is high and full is low. func 0 inserts a task, 1
// extracts the highest ranked one; higher priority wins, equal priorities
// go to the older id.
// Result channel: empty/pop. One result per item, in order, holding status,
// the extracted task (or assigned id), the new root priority and occupancy.
// From accept to result: a refused item, a first insert or the extract of
// the last task go straight to the result. Any other insert sifts up one
// level at a time until it stops or reaches the root; any other extract
// sifts the former last entry down, reading the left and then the right
// child at each level. The heap RAM has one registered read port. Items
// are handled one at a time; the front queues two items meanwhile.
// Reset clears occupancy and the id counter at once; the RAM is not cleared.
// If the receiver does not pop, the back holds its result and stops taking
// commands; once the two-entry queue fills, full is raised.
module max_heap_priority_queue_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire mhpq_pkg::in_item_t in_item,
  output logic                    empty,
  input  wire logic               pop,
  output mhpq_pkg::out_item_t     out_item
);
  logic cmd_valid, cmd_take;
  mhpq_pkg::cmd_t cmd;

  mhpq_front u_front (.clk, .rst, .push, .full, .in_item, .cmd_valid, .cmd, .cmd_take);
  mhpq_back  u_back  (.clk, .rst, .cmd_valid, .cmd, .cmd_take, .empty, .pop, .out_item);
endmodule
`default_nettype wire

>>> rtl/core/mhpq_checker.sv
`default_nettype none
module mhpq_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire mhpq_pkg::out_item_t out_item
);
  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(out_item)) else $error("result changed while stalled");
  // Occupancy never exceeds the heap depth.
  a_occ: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.occupancy <= 7'(mhpq_pkg::HEAP_DEPTH)) else $error("occupancy");
  // An empty heap reports a zero top priority.
  a_top: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.occupancy == 7'd0 |-> out_item.top_priority == 8'd0)
    else $error("top of empty heap");
  // After reset the block is ready and has no result.
  a_rst: assert property (@(posedge clk) rst |=> empty && !full) else $error("reset");
endmodule

bind max_heap_priority_queue_unit mhpq_checker u_chk (.clk, .rst, .full, .empty, .pop,
  .out_item);
`default_nettype wire
